// File: design/afs_pkg.sv
package afs_pkg;

  // Table geometry and field widths
  localparam int MAX_FRAMES = 64;
  localparam int SLOT_W     = $clog2(MAX_FRAMES);
  localparam int LEN_W      = 7;
  localparam int ID_W       = 16;
  localparam int DUR_W      = 16;
  localparam int ENTRY_W    = ID_W + DUR_W;
  localparam int TIME_W     = 32;
  localparam int ACC_W      = 32;
  // Looping total: at most 2*MAX_FRAMES-2 durations of DUR_W bits
  localparam int TOTAL_W    = 24;
  localparam int PASS_W     = 8;
  localparam int DIR_W      = 2;
  localparam int DIV_CNT_W  = $clog2(TIME_W);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_PLAY_DIR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOPING  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEN = 2'd3;

  // Play direction codes (code 3 plays forward)
  localparam logic [DIR_W-1:0] DIR_REV  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_PING = 2'd2;

  // Item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_DIV,
    S_WALK,
    S_DONE
  } afs_state_e;

  // Slot sequencer control and status
  typedef struct packed {
    logic              start;
    logic              loop_mode;
    logic [DIR_W-1:0]  dir;
    logic [LEN_W-1:0]  n;
    logic [PASS_W-1:0] passes;
  } seq_ctrl_t;

  typedef struct packed {
    logic              active;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } seq_stat_t;

  // Remainder unit request and response
  typedef struct packed {
    logic               start;
    logic [TIME_W-1:0]  dividend;
    logic [TOTAL_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic               done;
    logic [TOTAL_W-1:0] rem;
  } mod_rsp_t;

endpackage

// File: design/afs_mod.sv
// Bit-serial floored remainder of a signed time by an unsigned total.
// One dividend bit per cycle; done pulses in the cycle after the last step.
module afs_mod (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  afs_pkg::mod_req_t req_i,
  output afs_pkg::mod_rsp_t rsp_o
);

  logic                             busy_q, busy_d;
  logic                             done_q, done_d;
  logic [afs_pkg::DIV_CNT_W-1:0]    cnt_q, cnt_d;
  logic [afs_pkg::TIME_W-1:0]       dvd_q, dvd_d;
  logic [afs_pkg::TOTAL_W-1:0]      rem_q, rem_d;
  logic [afs_pkg::TOTAL_W-1:0]      dsr_q, dsr_d;
  logic                             neg_q, neg_d;
  logic [afs_pkg::TOTAL_W:0]        cand;
  logic [afs_pkg::TOTAL_W:0]        diff;

  // Restoring step: shift in next bit, subtract divisor when it fits
  always_comb begin
    cand   = {rem_q, dvd_q[afs_pkg::TIME_W-1]};
    diff   = cand - {1'b0, dsr_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    neg_d  = neg_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '1;
      neg_d  = req_i.dividend[afs_pkg::TIME_W-1];
      dvd_d  = req_i.dividend[afs_pkg::TIME_W-1] ?
               (~req_i.dividend + afs_pkg::TIME_W'(1)) : req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      // no borrow means cand >= divisor
      rem_d = diff[afs_pkg::TOTAL_W] ? cand[afs_pkg::TOTAL_W-1:0]
                                     : diff[afs_pkg::TOTAL_W-1:0];
      dvd_d = dvd_q << 1;
      cnt_d = cnt_q - afs_pkg::DIV_CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    neg_q <= neg_d;
  end

  // Negative dividend: fold a nonzero remainder back into [0, total)
  assign rsp_o.done = done_q;
  assign rsp_o.rem  = (neg_q && (rem_q != '0)) ? (dsr_q - rem_q) : rem_q;

endmodule

// File: design/afs_seq.sv
// Slot sequencer: walks the table in play order, one slot per advance.
// Looping: one pass (ping-pong adds a reverse pass over the interior).
// One-shot: a pass per repeat, ping-pong reverses on odd passes.
module afs_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  afs_pkg::seq_ctrl_t ctrl_i,
  input  logic               adv_i,
  output afs_pkg::seq_stat_t stat_o
);

  logic                          act_q, act_d;
  logic [afs_pkg::SLOT_W-1:0]    idx_q, idx_d;
  logic [afs_pkg::SLOT_W-1:0]    end_q, end_d;
  logic [afs_pkg::PASS_W-1:0]    pass_q, pass_d;
  logic [afs_pkg::LEN_W-1:0]     n_m1;
  logic [afs_pkg::LEN_W-1:0]     n_m2;
  logic                          rev;
  logic                          pass_end;
  logic                          more_pass;

  // Slot mapping and pass bookkeeping
  always_comb begin
    n_m1     = ctrl_i.n - afs_pkg::LEN_W'(1);
    n_m2     = ctrl_i.n - afs_pkg::LEN_W'(2);
    rev      = (ctrl_i.dir == afs_pkg::DIR_REV) ||
               ((ctrl_i.dir == afs_pkg::DIR_PING) && pass_q[0]);
    pass_end = (idx_q == end_q);
    if (ctrl_i.loop_mode) begin
      more_pass = (ctrl_i.dir == afs_pkg::DIR_PING) && (pass_q == '0) &&
                  (ctrl_i.n >= afs_pkg::LEN_W'(3));
    end else begin
      more_pass = (pass_q != (ctrl_i.passes - afs_pkg::PASS_W'(1)));
    end
  end

  assign stat_o.active = act_q;
  assign stat_o.slot   = rev ? (n_m1[afs_pkg::SLOT_W-1:0] - idx_q) : idx_q;
  assign stat_o.last   = pass_end && !more_pass;

  // Index advance
  always_comb begin
    act_d  = act_q;
    idx_d  = idx_q;
    end_d  = end_q;
    pass_d = pass_q;
    if (ctrl_i.start) begin
      act_d  = 1'b1;
      idx_d  = '0;
      end_d  = n_m1[afs_pkg::SLOT_W-1:0];
      pass_d = '0;
    end else if (adv_i && act_q) begin
      if (!pass_end) begin
        idx_d = idx_q + afs_pkg::SLOT_W'(1);
      end else if (more_pass) begin
        pass_d = pass_q + afs_pkg::PASS_W'(1);
        idx_d  = afs_pkg::SLOT_W'(ctrl_i.loop_mode);
        end_d  = ctrl_i.loop_mode ? n_m2[afs_pkg::SLOT_W-1:0]
                                  : n_m1[afs_pkg::SLOT_W-1:0];
      end else begin
        act_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      idx_q  <= '0;
      end_q  <= '0;
      pass_q <= '0;
    end else begin
      act_q  <= act_d;
      idx_q  <= idx_d;
      end_q  <= end_d;
      pass_q <= pass_d;
    end
  end

endmodule

// File: design/animation_frame_selector.sv
// Animation frame selector.
// Command channel: an item transfers when start is high and busy is low.
// kind 0 writes slot_i of the frame table (id, duration) in that cycle and
// leaves busy low. kind 1 queries the frame at time_ms_i; busy stays high
// until the result, shown for one cycle with done_o (frame_id_o, found_o).
// The receiver cannot stall; a result is never held back.
// Config channel: cfg_index_i/cfg_data_i transfer on cfg_valid_i&cfg_ready_o;
// ready is high while idle.
// A looping query sums the played sequence (n entries, or 2n-2 ping-pong),
// takes the remainder of the time by a nonzero total, then walks to the hit;
// a one-shot query walks P passes of n entries (P the pass count) and stops
// at the hit. An empty clip goes straight to the result. Queries are paced
// by the single read port (an entry per cycle) and remainder (bit per cycle).
// Throughput: one write per cycle while idle; a query holds the channel until
// its result, and the next transfer can come in the cycle after done_o.
// Reset restores the register defaults (looping on, all else zero) and
// idles the sequencer; table contents stay undefined until written.
module animation_frame_selector (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic                             kind_i,
  input  logic [afs_pkg::SLOT_W-1:0]       slot_i,
  input  logic [afs_pkg::ID_W-1:0]         entry_frame_id_i,
  input  logic [afs_pkg::DUR_W-1:0]        entry_duration_ms_i,
  input  logic signed [afs_pkg::TIME_W-1:0] time_ms_i,
  output logic                             done_o,
  output logic [afs_pkg::ID_W-1:0]         frame_id_o,
  output logic                             found_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [afs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [afs_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  afs_pkg::afs_state_e state_q, state_d;

  logic [afs_pkg::DIR_W-1:0]    dir_q;
  logic                         looping_q;
  logic [afs_pkg::PASS_W-1:0]   repeat_q;
  logic [afs_pkg::LEN_W-1:0]    clip_len_q;

  logic [afs_pkg::ENTRY_W-1:0]  mem_q [afs_pkg::MAX_FRAMES];
  logic [afs_pkg::ENTRY_W-1:0]  rd_q;
  logic                         rd_vld_q;
  logic                         rd_last_q;

  logic [afs_pkg::TIME_W-1:0]   time_q, time_d;
  logic [afs_pkg::ACC_W-1:0]    acc_q, acc_d;
  logic [afs_pkg::ID_W-1:0]     last_id_q, last_id_d;
  logic                         have_last_q, have_last_d;
  logic                         zero_total_q, zero_total_d;
  logic [afs_pkg::ID_W-1:0]     frame_q, frame_d;
  logic                         found_q, found_d;

  logic                         cfg_we;
  logic                         accept;
  logic                         wr_acc;
  logic                         q_acc;
  logic [afs_pkg::LEN_W-1:0]    n_used;
  logic [afs_pkg::PASS_W-1:0]   passes;
  logic                         adv;
  logic [afs_pkg::ID_W-1:0]     rd_id;
  logic [afs_pkg::ACC_W-1:0]    dur_ext;
  logic [afs_pkg::TIME_W-1:0]   tt;
  logic                         walk_sub;
  logic [afs_pkg::ACC_W-1:0]    addsub;
  logic                         skip;
  logic                         hit;
  logic                         sum_zero;

  afs_pkg::seq_ctrl_t seq_ctrl;
  afs_pkg::seq_stat_t seq_stat;
  afs_pkg::mod_req_t  mod_req;
  afs_pkg::mod_rsp_t  mod_rsp;

  // Handshakes
  assign busy        = (state_q != afs_pkg::S_IDLE);
  assign cfg_ready_o = !busy;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign accept      = start && !busy;
  assign wr_acc      = accept && (kind_i == afs_pkg::KIND_WRITE);
  assign q_acc       = accept && (kind_i == afs_pkg::KIND_QUERY);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q      <= '0;
      looping_q  <= 1'b1;
      repeat_q   <= '0;
      clip_len_q <= '0;
    end else if (cfg_we) begin
      case (cfg_index_i)
        afs_pkg::CFG_PLAY_DIR: dir_q      <= cfg_data_i[afs_pkg::DIR_W-1:0];
        afs_pkg::CFG_LOOPING:  looping_q  <= cfg_data_i[0];
        afs_pkg::CFG_REPEAT:   repeat_q   <= cfg_data_i[afs_pkg::PASS_W-1:0];
        afs_pkg::CFG_CLIP_LEN: clip_len_q <= cfg_data_i[afs_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign n_used = (clip_len_q > afs_pkg::LEN_W'(afs_pkg::MAX_FRAMES)) ?
                  afs_pkg::LEN_W'(afs_pkg::MAX_FRAMES) : clip_len_q;
  assign passes = (repeat_q == '0) ? afs_pkg::PASS_W'(1) : repeat_q;

  // Frame table: id in the upper half, duration in the lower half
  always_ff @(posedge clk_i) begin
    if (wr_acc) begin
      mem_q[slot_i] <= {entry_frame_id_i, entry_duration_ms_i};
    end
    rd_q <= mem_q[seq_stat.slot];
  end

  // Read tracking: data is valid in the cycle after the slot is issued
  assign adv = (state_q == afs_pkg::S_SUM) || (state_q == afs_pkg::S_WALK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      rd_last_q <= 1'b0;
    end else begin
      rd_vld_q  <= adv && seq_stat.active;
      rd_last_q <= seq_stat.last;
    end
  end

  // Shared add/subtract and compare on the entry just read
  always_comb begin
    rd_id    = rd_q[afs_pkg::ENTRY_W-1:afs_pkg::DUR_W];
    dur_ext  = afs_pkg::ACC_W'(rd_q[afs_pkg::DUR_W-1:0]);
    tt       = time_q[afs_pkg::TIME_W-1] ? '0 : time_q;
    walk_sub = looping_q && (state_q == afs_pkg::S_WALK);
    addsub   = walk_sub ? (acc_q - dur_ext) : (acc_q + dur_ext);
    skip     = !looping_q && have_last_q && (rd_id == last_id_q);
    hit      = looping_q ? (zero_total_q || (acc_q < dur_ext))
                         : (!skip && (tt < addsub));
    sum_zero = (addsub == '0);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      afs_pkg::S_IDLE: begin
        if (q_acc) begin
          if (n_used == '0) begin
            state_d = afs_pkg::S_DONE;
          end else if (looping_q) begin
            state_d = afs_pkg::S_SUM;
          end else begin
            state_d = afs_pkg::S_WALK;
          end
        end
      end
      afs_pkg::S_SUM: begin
        if (rd_vld_q && rd_last_q) begin
          state_d = sum_zero ? afs_pkg::S_WALK : afs_pkg::S_DIV;
        end
      end
      afs_pkg::S_DIV: begin
        if (mod_rsp.done) begin
          state_d = afs_pkg::S_WALK;
        end
      end
      afs_pkg::S_WALK: begin
        if (rd_vld_q && (hit || rd_last_q)) begin
          state_d = afs_pkg::S_DONE;
        end
      end
      afs_pkg::S_DONE: begin
        state_d = afs_pkg::S_IDLE;
      end
      default: begin
        state_d = afs_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath updates per state
  always_comb begin
    time_d       = time_q;
    acc_d        = acc_q;
    last_id_d    = last_id_q;
    have_last_d  = have_last_q;
    zero_total_d = zero_total_q;
    frame_d      = frame_q;
    found_d      = found_q;
    case (state_q)
      afs_pkg::S_IDLE: begin
        if (q_acc) begin
          time_d       = time_ms_i;
          acc_d        = '0;
          have_last_d  = 1'b0;
          zero_total_d = 1'b0;
          frame_d      = '0;
          found_d      = 1'b0;
        end
      end
      afs_pkg::S_SUM: begin
        if (rd_vld_q) begin
          acc_d = addsub;
          if (rd_last_q) begin
            zero_total_d = sum_zero;
          end
        end
      end
      afs_pkg::S_DIV: begin
        if (mod_rsp.done) begin
          acc_d = afs_pkg::ACC_W'(mod_rsp.rem);
        end
      end
      afs_pkg::S_WALK: begin
        if (rd_vld_q) begin
          if (looping_q) begin
            if (!hit) begin
              acc_d = addsub;
            end
          end else if (!skip) begin
            acc_d       = addsub;
            last_id_d   = rd_id;
            have_last_d = 1'b1;
          end
          // a skipped entry repeats the last id, so the fallback is rd_id
          if (hit || rd_last_q) begin
            frame_d = rd_id;
            found_d = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= afs_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    time_q       <= time_d;
    acc_q        <= acc_d;
    last_id_q    <= last_id_d;
    have_last_q  <= have_last_d;
    zero_total_q <= zero_total_d;
    frame_q      <= frame_d;
    found_q      <= found_d;
  end

  // Slot sequencer, restarted on entry to each walk
  always_comb begin
    seq_ctrl.start     = (state_d != state_q) &&
                         ((state_d == afs_pkg::S_SUM) || (state_d == afs_pkg::S_WALK));
    seq_ctrl.loop_mode = looping_q;
    seq_ctrl.dir       = dir_q;
    seq_ctrl.n         = n_used;
    seq_ctrl.passes    = passes;
  end

  afs_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (seq_ctrl),
    .adv_i  (adv),
    .stat_o (seq_stat)
  );

  // Remainder unit, started with the final total of the sum walk
  always_comb begin
    mod_req.start    = (state_q == afs_pkg::S_SUM) && (state_d == afs_pkg::S_DIV);
    mod_req.dividend = time_q;
    mod_req.divisor  = addsub[afs_pkg::TOTAL_W-1:0];
  end

  afs_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  // Result
  assign done_o     = (state_q == afs_pkg::S_DONE);
  assign frame_id_o = frame_q;
  assign found_o    = found_q;

  // Checks
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !found_o) |-> (frame_id_o == '0))
    else $error("not-found result carries a nonzero frame id");

  a_div_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == afs_pkg::S_DIV) |-> !rd_vld_q)
    else $error("table read still in flight during remainder step");

  a_mod_done_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_rsp.done |-> (state_q == afs_pkg::S_DIV))
    else $error("remainder unit finished outside its state");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_acc |=> busy)
    else $error("query transfer did not raise busy");

  a_strobe_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

endmodule
